// File: sv/fds_pkg.sv
package fds_pkg;

  localparam int REG_W    = 13;
  localparam int PIX_W    = 8;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int SUM_DEPTH = 2048;
  localparam int SUM_AW   = 11;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] REG_SRC_W = 3'd0;
  localparam logic [2:0] REG_SRC_H = 3'd1;
  localparam logic [2:0] REG_TGT_W = 3'd2;
  localparam logic [2:0] REG_TGT_H = 3'd3;
  localparam logic [2:0] REG_AVG   = 3'd4;

  localparam logic [REG_W-1:0] RST_SRC_W = 13'd1920;
  localparam logic [REG_W-1:0] RST_SRC_H = 13'd1080;
  localparam logic [REG_W-1:0] RST_TGT_W = 13'd960;
  localparam logic [REG_W-1:0] RST_TGT_H = 13'd540;

  typedef enum logic [2:0] {
    ST_RATIO_GO,
    ST_RATIO_WAIT,
    ST_POS_GO,
    ST_POS_WAIT,
    ST_RUN
  } geom_state_t;

endpackage

// File: sv/fds_div.sv
module fds_div #(
  parameter int NW = 13,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int KW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [KW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // One quotient bit per cycle, restoring form; the dividend shifts out
  // of q_r as the quotient shifts in.
  assign trial = {rem_r, q_r[NW-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == KW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= KW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - KW'(1);
        if (cnt_r == KW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// File: sv/frame_downscaler_box_or_nearest_top.sv
// A nearest-mode result is registered in stage 1 and then in the output queue; a box mean goes
// from stage 1 through the three mean dividers and their done register before it reaches the queue.
// A request is taken only while stage 1 and the two-entry output queue hold at most one pixel,
// and the last pixel of a box block holds the input off while its mean is divided.
// Reset and every register write start a geometry pass that takes no input.
module frame_downscaler_box_or_nearest_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue_in, green_in, red_in
  input  logic        in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red_out, green_out, blue_out
  output logic        out_tuser,  // row_end
  output logic        out_tlast,  // frame_end
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = XW + YW;
  localparam int PW    = fds_pkg::PIX_W;
  localparam int SW    = PW + CW;
  localparam int RW    = fds_pkg::REG_W;
  localparam int QW    = 3 * PW + 2;
  localparam logic [RW:0] MAXW_L = (RW + 1)'(MAX_WIDTH);
  localparam logic [RW:0] MAXH_L = (RW + 1)'(MAX_HEIGHT);

  // Configuration registers
  logic [RW-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic          avg_r;
  logic          cfg_wr;
  logic [2:0]    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= fds_pkg::RST_SRC_W;
      src_h_r <= fds_pkg::RST_SRC_H;
      tgt_w_r <= fds_pkg::RST_TGT_W;
      tgt_h_r <= fds_pkg::RST_TGT_H;
      avg_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fds_pkg::REG_SRC_W: src_w_r <= cfg_pwdata[RW-1:0];
        fds_pkg::REG_SRC_H: src_h_r <= cfg_pwdata[RW-1:0];
        fds_pkg::REG_TGT_W: tgt_w_r <= cfg_pwdata[RW-1:0];
        fds_pkg::REG_TGT_H: tgt_h_r <= cfg_pwdata[RW-1:0];
        fds_pkg::REG_AVG:   avg_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fds_pkg::REG_SRC_W: cfg_prdata = 32'(src_w_r);
      fds_pkg::REG_SRC_H: cfg_prdata = 32'(src_h_r);
      fds_pkg::REG_TGT_W: cfg_prdata = 32'(tgt_w_r);
      fds_pkg::REG_TGT_H: cfg_prdata = 32'(tgt_h_r);
      fds_pkg::REG_AVG:   cfg_prdata = 32'(avg_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, source clamps to the maximum, target to source.
  logic [XW-1:0] sw, tw;
  logic [YW-1:0] sh, th;

  always_comb begin
    if (src_w_r == '0) sw = XW'(1);
    else if ({1'b0, src_w_r} > MAXW_L) sw = XW'(MAX_WIDTH);
    else sw = XW'(src_w_r);
    if (src_h_r == '0) sh = YW'(1);
    else if ({1'b0, src_h_r} > MAXH_L) sh = YW'(MAX_HEIGHT);
    else sh = YW'(src_h_r);
    if (tgt_w_r == '0) tw = XW'(1);
    else if ({1'b0, tgt_w_r} > (RW + 1)'(sw)) tw = sw;
    else tw = XW'(tgt_w_r);
    if (tgt_h_r == '0) th = YW'(1);
    else if ({1'b0, tgt_h_r} > (RW + 1)'(sh)) th = sh;
    else th = YW'(tgt_h_r);
  end

  // Geometry sequencer
  fds_pkg::geom_state_t state_r, state_nxt;
  logic          pos_phase;
  logic          geo_start;
  logic          dx_busy, dy_busy;
  logic [XW-1:0] dx_q, dx_rem, dx_n, dx_d;
  logic [YW-1:0] dy_q, dy_rem, dy_n, dy_d;

  logic [XW-1:0] c_r, ox_r, sx_r, rx_r, rxm1_r;
  logic [YW-1:0] y_r, oy_r, sy_r, ry_r, rym1_r;
  logic [CW-1:0] cnt_r;
  logic          box_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fds_pkg::ST_RATIO_GO:   state_nxt = fds_pkg::ST_RATIO_WAIT;
      fds_pkg::ST_RATIO_WAIT: if (!dx_busy && !dy_busy) state_nxt = fds_pkg::ST_POS_GO;
      fds_pkg::ST_POS_GO:     state_nxt = fds_pkg::ST_POS_WAIT;
      fds_pkg::ST_POS_WAIT:   if (!dx_busy && !dy_busy) state_nxt = fds_pkg::ST_RUN;
      fds_pkg::ST_RUN:        state_nxt = fds_pkg::ST_RUN;
      default:                state_nxt = fds_pkg::ST_RATIO_GO;
    endcase
    if (cfg_wr) begin
      state_nxt = fds_pkg::ST_RATIO_GO;
    end
  end

  always_comb begin
    geo_start = (state_r == fds_pkg::ST_RATIO_GO) || (state_r == fds_pkg::ST_POS_GO);
    pos_phase = (state_r == fds_pkg::ST_POS_GO) || (state_r == fds_pkg::ST_POS_WAIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= fds_pkg::ST_RATIO_GO;
    else        state_r <= state_nxt;
  end

  // The ratio pass divides source by target size; the position pass divides the
  // live counters by the ratios, so counters stay exact across a size change.
  assign dx_n = pos_phase ? c_r  : sw;
  assign dx_d = pos_phase ? rx_r : tw;
  assign dy_n = pos_phase ? y_r  : sh;
  assign dy_d = pos_phase ? ry_r : th;

  fds_div #(.NW(XW), .DW(XW)) u_div_x (
    .clk, .rst_n, .start(geo_start), .dividend(dx_n), .divisor(dx_d),
    .busy(dx_busy), .done(), .quotient(dx_q), .remainder(dx_rem)
  );

  fds_div #(.NW(YW), .DW(YW)) u_div_y (
    .clk, .rst_n, .start(geo_start), .dividend(dy_n), .divisor(dy_d),
    .busy(dy_busy), .done(), .quotient(dy_q), .remainder(dy_rem)
  );

  always_ff @(posedge clk) begin
    if (state_r == fds_pkg::ST_RATIO_WAIT && !dx_busy && !dy_busy) begin
      rx_r <= dx_q;
      ry_r <= dy_q;
    end
    if (state_r == fds_pkg::ST_POS_GO) begin
      cnt_r  <= CW'(rx_r) * CW'(ry_r);
      box_r  <= avg_r && (rx_r > XW'(1)) && (ry_r > YW'(1));
      rxm1_r <= rx_r - XW'(1);
      rym1_r <= ry_r - YW'(1);
    end
  end

  // Stage 0: position of the accepted pixel
  logic          in_acc;
  logic          fs;
  logic [XW-1:0] c0, ox0, sx0;
  logic [YW-1:0] y0, oy0, sy0;
  logic          inr0, first0, last0, re0, fe0;
  logic [XW-1:0] c_nxt, ox_nxt, sx_nxt;
  logic [YW-1:0] y_nxt, oy_nxt, sy_nxt;

  assign in_acc = in_tvalid && in_tready;
  assign fs     = in_tuser;

  always_comb begin
    c0  = fs ? '0 : c_r;
    ox0 = fs ? '0 : ox_r;
    sx0 = fs ? '0 : sx_r;
    y0  = fs ? '0 : y_r;
    oy0 = fs ? '0 : oy_r;
    sy0 = fs ? '0 : sy_r;
    inr0   = (ox0 < tw) && (oy0 < th);
    first0 = (sx0 == '0) && (sy0 == '0);
    last0  = (sx0 == rxm1_r) && (sy0 == rym1_r);
    re0    = ox0 == (tw - XW'(1));
    fe0    = re0 && (oy0 == (th - YW'(1)));

    y_nxt  = y0;
    oy_nxt = oy0;
    sy_nxt = sy0;
    if ((c0 + XW'(1)) >= sw) begin
      c_nxt  = '0;
      ox_nxt = '0;
      sx_nxt = '0;
      if ((y0 + YW'(1)) >= sh) begin
        y_nxt  = '0;
        oy_nxt = '0;
        sy_nxt = '0;
      end else begin
        y_nxt = y0 + YW'(1);
        if (sy0 == rym1_r) begin
          sy_nxt = '0;
          oy_nxt = oy0 + YW'(1);
        end else begin
          sy_nxt = sy0 + YW'(1);
        end
      end
    end else begin
      c_nxt = c0 + XW'(1);
      if (sx0 == rxm1_r) begin
        sx_nxt = '0;
        ox_nxt = ox0 + XW'(1);
      end else begin
        sx_nxt = sx0 + XW'(1);
        ox_nxt = ox0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r  <= '0;
      y_r  <= '0;
      ox_r <= '0;
      sx_r <= '0;
      oy_r <= '0;
      sy_r <= '0;
    end else if (state_r == fds_pkg::ST_POS_WAIT && !dx_busy && !dy_busy) begin
      ox_r <= dx_q;
      sx_r <= dx_rem;
      oy_r <= dy_q;
      sy_r <= dy_rem;
    end else if (in_acc) begin
      c_r  <= c_nxt;
      y_r  <= y_nxt;
      ox_r <= ox_nxt;
      sx_r <= sx_nxt;
      oy_r <= oy_nxt;
      sy_r <= sy_nxt;
    end
  end

  // Stage 1 registers
  logic                      p1_valid_r, p1_box_r, p1_near_r;
  logic                      p1_first_r, p1_last_r, p1_re_r, p1_fe_r;
  logic [fds_pkg::SUM_AW-1:0] p1_idx_r;
  logic [PW-1:0]             p1_red_r, p1_green_r, p1_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_box_r   <= inr0 && box_r;
      p1_near_r  <= inr0 && !box_r && first0;
      p1_first_r <= first0;
      p1_last_r  <= last0;
      p1_re_r    <= re0;
      p1_fe_r    <= fe0;
      p1_idx_r   <= fds_pkg::SUM_AW'(ox0);
      p1_blue_r  <= in_tdata[7:0];
      p1_green_r <= in_tdata[15:8];
      p1_red_r   <= in_tdata[23:16];
    end
  end

  // Column sum memory: {blue, green, red}, read in stage 0, written in stage 1.
  logic [3*SW-1:0] sum_mem [fds_pkg::SUM_DEPTH];
  logic [3*SW-1:0] rd_q_r;
  logic [3*SW-1:0] wr_data_r;
  logic [fds_pkg::SUM_AW-1:0] wr_idx_r;
  logic            wr_valid_r;
  logic            rd_en, wr_en;
  logic [3*SW-1:0] old_word, new_word;
  logic [SW-1:0]   sum_r, sum_g, sum_b;

  assign rd_en = in_acc && inr0 && box_r;
  assign wr_en = p1_valid_r && p1_box_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= sum_mem[fds_pkg::SUM_AW'(ox0)];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sum_mem[p1_idx_r] <= new_word;
    end
  end

  // The write of the previous pixel lands on the same edge as this pixel's read,
  // so for a same-column read the value just written is taken from wr_data_r instead.
  always_comb begin
    if (wr_valid_r && (wr_idx_r == p1_idx_r)) old_word = wr_data_r;
    else old_word = rd_q_r;
    if (p1_first_r) begin
      sum_r = SW'(p1_red_r);
      sum_g = SW'(p1_green_r);
      sum_b = SW'(p1_blue_r);
    end else begin
      sum_r = old_word[SW-1:0] + SW'(p1_red_r);
      sum_g = old_word[2*SW-1:SW] + SW'(p1_green_r);
      sum_b = old_word[3*SW-1:2*SW] + SW'(p1_blue_r);
    end
    new_word = {sum_b, sum_g, sum_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_valid_r <= 1'b0;
    end else begin
      wr_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wr_idx_r  <= p1_idx_r;
      wr_data_r <= new_word;
    end
  end

  // Box mean: three dividers in step, one quotient bit per cycle.
  logic          mean_start, mean_busy, mean_done;
  logic          mr_busy, mr_done;
  logic [SW-1:0] mr_q, mg_q, mb_q;
  logic          mean_re_r, mean_fe_r;

  assign mean_start = wr_en && p1_last_r;
  assign mean_busy  = mr_busy || mr_done;
  assign mean_done  = mr_done;

  fds_div #(.NW(SW), .DW(CW)) u_mean_r (
    .clk, .rst_n, .start(mean_start), .dividend(sum_r), .divisor(cnt_r),
    .busy(mr_busy), .done(mr_done), .quotient(mr_q), .remainder()
  );

  fds_div #(.NW(SW), .DW(CW)) u_mean_g (
    .clk, .rst_n, .start(mean_start), .dividend(sum_g), .divisor(cnt_r),
    .busy(), .done(), .quotient(mg_q), .remainder()
  );

  fds_div #(.NW(SW), .DW(CW)) u_mean_b (
    .clk, .rst_n, .start(mean_start), .dividend(sum_b), .divisor(cnt_r),
    .busy(), .done(), .quotient(mb_q), .remainder()
  );

  always_ff @(posedge clk) begin
    if (mean_start) begin
      mean_re_r <= p1_re_r;
      mean_fe_r <= p1_fe_r;
    end
  end

  // Two-entry output queue: {frame_end, row_end, blue, green, red}
  logic [QW-1:0] oq_r [2];
  logic          oq_wp_r, oq_rp_r;
  logic [1:0]    out_cnt_r;
  logic          near_push, fifo_push, fifo_pop;
  logic [QW-1:0] push_data, head;

  assign near_push = p1_valid_r && p1_near_r;
  assign fifo_push = near_push || mean_done;
  assign fifo_pop  = out_tvalid && out_tready;

  always_comb begin
    if (mean_done) begin
      push_data = {mean_fe_r, mean_re_r, mb_q[PW-1:0], mg_q[PW-1:0], mr_q[PW-1:0]};
    end else begin
      push_data = {p1_fe_r, p1_re_r, p1_blue_r, p1_green_r, p1_red_r};
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      oq_r[oq_wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r   <= 1'b0;
      oq_rp_r   <= 1'b0;
      out_cnt_r <= 2'd0;
    end else begin
      if (fifo_push) oq_wp_r <= ~oq_wp_r;
      if (fifo_pop)  oq_rp_r <= ~oq_rp_r;
      out_cnt_r <= out_cnt_r + 2'(fifo_push) - 2'(fifo_pop);
    end
  end

  assign head       = oq_r[oq_rp_r];
  assign out_tvalid = out_cnt_r != 2'd0;
  assign out_tdata  = head[3*PW-1:0];
  assign out_tuser  = head[3*PW];
  assign out_tlast  = head[3*PW+1];

  // A pixel waiting in stage 1 may still push a result, so it counts against the queue.
  assign in_tready = (state_r == fds_pkg::ST_RUN) && !mean_busy
                     && !(p1_valid_r && p1_box_r && p1_last_r)
                     && ((3'(out_cnt_r) + 3'(p1_valid_r)) < 3'd2);

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_push && !fifo_pop && out_cnt_r == 2'd2))
    else $error("output queue overflow");

  a_mean_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mean_start |-> !mean_busy)
    else $error("mean divider restarted while busy");

  a_single_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(near_push && mean_done))
    else $error("nearest and mean results pushed together");

  a_geom_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != fds_pkg::ST_RUN) |-> !p1_valid_r || $past(state_r == fds_pkg::ST_RUN))
    else $error("pixel in flight during geometry pass");

endmodule

// File: bench/tb_frame_downscaler_box_or_nearest_top.sv
`timescale 1ns / 1ps

module tb_frame_downscaler_box_or_nearest_top;

  localparam int MAX_W       = 4096;
  localparam int MAX_H       = 4096;
  localparam int ITEM_GOAL   = 900;
  localparam int SETTLE_CYC  = 60;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } out_pix_t;

  class downscale_scoreboard;
    logic [fds_pkg::REG_W-1:0] src_w, src_h, tgt_w, tgt_h;
    logic             avg_mode;
    int unsigned      col, row;
    int unsigned      red_sum[fds_pkg::SUM_DEPTH];
    int unsigned      green_sum[fds_pkg::SUM_DEPTH];
    int unsigned      blue_sum[fds_pkg::SUM_DEPTH];
    out_pix_t         pending_q[$];
    int               mismatches;

    function void reset_state();
      src_w = fds_pkg::RST_SRC_W;
      src_h = fds_pkg::RST_SRC_H;
      tgt_w = fds_pkg::RST_TGT_W;
      tgt_h = fds_pkg::RST_TGT_H;
      avg_mode = 1'b0;
      col = 0;
      row = 0;
      mismatches = 0;
    endfunction

    // Computes the output pixel, if any, caused by one accepted source pixel.
    function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
      int unsigned sw, sh, tw, th, rx, ry, ox, oy, sx, sy, idx, cnt;
      bit box, hit;
      out_pix_t p;
      sw = (src_w == 0) ? 1 : (src_w > MAX_W) ? MAX_W : src_w;
      sh = (src_h == 0) ? 1 : (src_h > MAX_H) ? MAX_H : src_h;
      tw = (tgt_w == 0) ? 1 : (tgt_w > sw) ? sw : tgt_w;
      th = (tgt_h == 0) ? 1 : (tgt_h > sh) ? sh : tgt_h;
      rx = sw / tw;
      ry = sh / th;
      box = avg_mode && rx > 1 && ry > 1;
      hit = 0;
      if (fs) begin
        col = 0;
        row = 0;
      end
      if (col < tw * rx && row < th * ry) begin
        ox = col / rx;
        oy = row / ry;
        sx = col - ox * rx;
        sy = row - oy * ry;
        if (box) begin
          idx = ox % fds_pkg::SUM_DEPTH;
          if (sx == 0 && sy == 0) begin
            red_sum[idx] = r;
            green_sum[idx] = g;
            blue_sum[idx] = b;
          end else begin
            red_sum[idx] += r;
            green_sum[idx] += g;
            blue_sum[idx] += b;
          end
          if (sx == rx - 1 && sy == ry - 1) begin
            cnt = rx * ry;
            p.red = 8'(red_sum[idx] / cnt);
            p.green = 8'(green_sum[idx] / cnt);
            p.blue = 8'(blue_sum[idx] / cnt);
            hit = 1;
          end
        end else if (sx == 0 && sy == 0) begin
          p.red = r;
          p.green = g;
          p.blue = b;
          hit = 1;
        end
        if (hit) begin
          p.row_end = (ox == tw - 1);
          p.frame_end = (ox == tw - 1) && (oy == th - 1);
          pending_q.push_back(p);
        end
      end
      col++;
      if (col >= sw) begin
        col = 0;
        row++;
        if (row >= sh) row = 0;
      end
    endfunction

    function void check_pixel(out_pix_t got);
      out_pix_t exp_pix;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected output pixel %h", got);
        return;
      end
      exp_pix = pending_q.pop_front();
      if (got.red !== exp_pix.red || got.green !== exp_pix.green ||
          got.blue !== exp_pix.blue || got.row_end !== exp_pix.row_end ||
          got.frame_end !== exp_pix.frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: pixel mismatch exp r=%h g=%h b=%h re=%b fe=%b got r=%h g=%h b=%h re=%b fe=%b",
                   exp_pix.red, exp_pix.green, exp_pix.blue, exp_pix.row_end,
                   exp_pix.frame_end, got.red, got.green, got.blue, got.row_end,
                   got.frame_end);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  downscale_scoreboard pix_sb = new();
  int pixels_sent = 0;
  int stall_cycles = 0;

  frame_downscaler_box_or_nearest_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic int sender_idle_pct();
    if (pixels_sent < 300) return 33;
    if (pixels_sent < 600) return 85;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (pixels_sent < 300) return 85;
    if (pixels_sent < 600) return 33;
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= receiver_idle_pct());
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      pix_sb.check_pixel('{out_tdata[7:0], out_tdata[15:8], out_tdata[23:16],
                           out_tuser, out_tlast});
  end

  // Any accepted request on either channel or the config port counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx) << 2;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (pix_sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_geometry(int sw, int sh, int tw, int th, bit avg);
    drain_outputs();
    write_reg(fds_pkg::REG_SRC_W, sw);
    write_reg(fds_pkg::REG_SRC_H, sh);
    write_reg(fds_pkg::REG_TGT_W, tw);
    write_reg(fds_pkg::REG_TGT_H, th);
    write_reg(fds_pkg::REG_AVG, 32'(avg));
    pix_sb.src_w = (fds_pkg::REG_W)'(sw);
    pix_sb.src_h = (fds_pkg::REG_W)'(sh);
    pix_sb.tgt_w = (fds_pkg::REG_W)'(tw);
    pix_sb.tgt_h = (fds_pkg::REG_W)'(th);
    pix_sb.avg_mode = avg;
  endtask

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
    while ($urandom_range(99) < sender_idle_pct()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {r, g, b};
    in_tuser <= fs;
    do @(posedge clk); while (!in_tready);
    pix_sb.note_pixel(b, g, r, fs);
    pixels_sent++;
  endtask

  // A new geometry always starts with a frame start, so no block is summed
  // from column sums left behind by another geometry.
  task automatic send_frame_run(int count, int fs_pct);
    for (int k = 0; k < count; k++)
      send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                 (k == 0) || ($urandom_range(99) < fs_pct));
  endtask

  initial begin
    int rx, ry, tw, th, sw, sh;
    pix_sb.reset_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry, nearest mode: extremes of the pixel bytes.
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'h0F, 1'b1);

    // Zero sizes act as one: every pixel ends a row and a frame.
    set_geometry(0, 0, 0, 0, 1);
    send_frame_run(5, 0);

    // Oversized source and target are clamped; nearest with one row of output.
    set_geometry(8191, 2, 8191, 1, 1);
    send_frame_run(5, 0);

    // Box 3x2 with full-scale pixels exercises the widest mean.
    set_geometry(6, 4, 2, 2, 1);
    for (int k = 0; k < 10; k++)
      send_pixel(8'hFF, 8'hFF, 8'hFF, k == 0);

    // Widest row in nearest mode.
    set_geometry(MAX_W, 1, MAX_W / 2, 1, 0);
    send_frame_run(200, 0);

    while (pixels_sent < ITEM_GOAL) begin
      rx = $urandom_range(1, 3);
      ry = $urandom_range(1, 3);
      tw = $urandom_range(1, 5);
      th = $urandom_range(1, 4);
      sw = tw * rx + $urandom_range(0, 2);
      sh = th * ry + $urandom_range(0, 2);
      if ($urandom_range(9) < 2) tw = sw + $urandom_range(1, 3);
      if ($urandom_range(9) < 2) th = sh + $urandom_range(1, 3);
      set_geometry(sw, sh, tw, th, $urandom_range(9) < 7);
      send_frame_run($urandom_range(40, 120), 2);
    end

    drain_outputs();
    if (pix_sb.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
